// ===== hw/rtl/ilwf_pkg.sv =====
// ilwf_pkg: shared types and constants for the instrument lookup block
// no dependencies; used by ilwf_match and the top level
package ilwf_pkg;

    // identifier layout {is_drum, bank_msb, bank_lsb, program}
    localparam int FIELD_W = 7;
    localparam int ID_W    = 1 + 3 * FIELD_W;

    localparam int ENTRY_COUNT_W = 9;
    localparam int ENTRY_INDEX_W = 8;
    localparam int FOUND_INDEX_W = 8;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    // register index taken from paddr bit 2
    localparam logic REG_ENTRY_COUNT = 1'b0;

    // item kinds carried in tuser
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        LVL_EXACT    = 2'd0,
        LVL_BANK0    = 2'd1,
        LVL_ALL0     = 2'd2,
        LVL_DEFAULT  = 2'd3
    } match_level_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } seq_state_t;

    // sequencer to match unit
    typedef struct packed {
        logic clear;
        logic cmp_en;
    } scan_ctrl_t;

endpackage

// ===== hw/rtl/instrument_lookup_with_fallback_top.sv =====
// instrument_lookup_with_fallback_top: instrument table with fallback lookup
// depends on ilwf_pkg, ilwf_ram, ilwf_match
//
// channel   direction  handshake          payload
// s_        in         s_tvalid/s_tready  s_tuser op, s_tdata entry/identifier
// m_        out        m_tvalid/m_tready  m_tdata found_index, match_level
// apb       in         psel/penable       entry_count at byte address 0
//
// a write transfer stores one entry
// a lookup transfer scans the first limit entries before the result can load,
// limit being entry_count capped at TABLE_DEPTH; the single ram read port and
// the one compare unit walk the table one entry per cycle
// s_tready is low while a lookup is scanning or its result waits to load
// the result sits in an output register; a stalled m_ side does not block write
// transfers until the next lookup result waits to load, which holds s_tready low
// reset (aresetn, synchronous) clears control state and entry_count; table
// contents are undefined until written
module instrument_lookup_with_fallback_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // [0] op
    input  logic [31:0] s_tdata,   // [7:0] entry_index, [8] is_drum, [15:9] bank_msb,
                                   // [22:16] bank_lsb, [29:23] program_req, [31:30] zero

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] found_index, [9:8] match_level, [15:10] zero

    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ilwf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ilwf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ilwf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int ID_W   = ilwf_pkg::ID_W;
    localparam int FW     = ilwf_pkg::FIELD_W;
    localparam int ECW    = ilwf_pkg::ENTRY_COUNT_W;
    localparam int EIW    = ilwf_pkg::ENTRY_INDEX_W;
    localparam int FIW    = ilwf_pkg::FOUND_INDEX_W;
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int PW     = (IDX_W > EIW) ? IDX_W : EIW;
    localparam int XW     = (IDX_W > FIW) ? IDX_W : FIW;
    localparam int LW     = (CNT_W > ECW) ? CNT_W : ECW;

    // input fields
    logic            in_op;
    logic [EIW-1:0]  in_entry_index;
    logic [ID_W-1:0] in_id;
    logic            s_fire;
    logic            wr_fire;
    logic            lookup_fire;

    assign in_op          = s_tuser;
    assign in_entry_index = s_tdata[EIW-1:0];
    // {is_drum, bank_msb, bank_lsb, program_req}
    assign in_id = {s_tdata[EIW],
                    s_tdata[EIW+FW:EIW+1],
                    s_tdata[EIW+2*FW:EIW+FW+1],
                    s_tdata[EIW+3*FW:EIW+2*FW+1]};

    assign s_fire      = s_tvalid && s_tready;
    assign wr_fire     = s_fire && (in_op == ilwf_pkg::OP_WRITE);
    assign lookup_fire = s_fire && (in_op == ilwf_pkg::OP_LOOKUP);

    // configuration register
    logic [ECW-1:0] entry_count_reg;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_wr && paddr[2] == ilwf_pkg::REG_ENTRY_COUNT) begin
            entry_count_reg <= pwdata[ECW-1:0];
        end
    end

    assign prdata = (paddr[2] == ilwf_pkg::REG_ENTRY_COUNT) ?
                    ilwf_pkg::APB_DATA_W'(entry_count_reg) : '0;

    // write path: entries beyond the table are dropped
    logic [PW-1:0]    wr_pos_ext;
    logic             wr_in_range;
    logic [IDX_W-1:0] wr_addr;

    assign wr_pos_ext  = PW'(in_entry_index);
    assign wr_in_range = ({1'b0, wr_pos_ext} < (PW + 1)'(TABLE_DEPTH));
    assign wr_addr     = wr_pos_ext[IDX_W-1:0];

    // scan limit: entry_count capped at the table depth
    logic [LW-1:0]    count_ext;
    logic [LW-1:0]    limit_wide;
    logic [CNT_W-1:0] limit_new;

    assign count_ext  = LW'(entry_count_reg);
    assign limit_wide = (count_ext > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : count_ext;
    assign limit_new  = limit_wide[CNT_W-1:0];

    // sequencer state
    ilwf_pkg::seq_state_t state_reg, state_next;
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic [ID_W-1:0]      key_reg, key_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 rd_issue;
    logic                 scan_done;
    logic                 out_free;
    logic                 out_load;
    ilwf_pkg::scan_ctrl_t scan_ctrl;

    // output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [FIW-1:0]         m_found_reg, m_found_next;
    ilwf_pkg::match_level_t m_level_reg, m_level_next;

    // match unit results
    logic [ID_W-1:0]        rd_entry;
    logic [IDX_W-1:0]       match_idx;
    ilwf_pkg::match_level_t match_level;
    logic [XW-1:0]          match_idx_ext;

    assign match_idx_ext = XW'(match_idx);
    assign out_free      = !m_tvalid_reg || m_tready;
    assign rd_issue      = (state_reg == ilwf_pkg::ST_SCAN) && (rd_cnt_reg < limit_reg);
    assign scan_done     = (rd_cnt_reg == limit_reg) && !rd_vld_reg;
    assign out_load      = (state_reg == ilwf_pkg::ST_RESULT) && out_free;

    // input side only takes transfers while idle
    assign s_tready = (state_reg == ilwf_pkg::ST_IDLE);

    assign scan_ctrl.clear  = lookup_fire;
    assign scan_ctrl.cmp_en = rd_vld_reg;

    always_comb begin
        state_next    = state_reg;
        rd_cnt_next   = rd_cnt_reg;
        limit_next    = limit_reg;
        key_next      = key_reg;
        rd_vld_next   = rd_issue;
        rd_idx_next   = rd_cnt_reg[IDX_W-1:0];
        m_tvalid_next = m_tvalid_reg;
        m_found_next  = m_found_reg;
        m_level_next  = m_level_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ilwf_pkg::ST_IDLE: begin
                if (lookup_fire) begin
                    key_next    = in_id;
                    limit_next  = limit_new;
                    rd_cnt_next = '0;
                    state_next  = ilwf_pkg::ST_SCAN;
                end
            end
            ilwf_pkg::ST_SCAN: begin
                if (rd_issue) begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (scan_done) begin
                    state_next = ilwf_pkg::ST_RESULT;
                end
            end
            ilwf_pkg::ST_RESULT: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = match_idx_ext[FIW-1:0];
                    m_level_next  = match_level;
                    state_next    = ilwf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ilwf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ilwf_pkg::ST_IDLE;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            rd_cnt_reg   <= '0;
            limit_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_cnt_reg   <= rd_cnt_next;
            limit_reg    <= limit_next;
        end
        key_reg     <= key_next;
        rd_idx_reg  <= rd_idx_next;
        m_found_reg <= m_found_next;
        m_level_reg <= m_level_next;
    end

    // instrument table
    ilwf_ram #(
        .WIDTH (ID_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_fire && wr_in_range),
        .wr_addr (wr_addr),
        .wr_data (in_id),
        .rd_en   (rd_issue),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    // shared compare unit, one entry per cycle
    ilwf_match #(
        .IDX_W (IDX_W)
    ) u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (scan_ctrl),
        .key       (key_reg),
        .entry     (rd_entry),
        .entry_idx (rd_idx_reg),
        .found_idx (match_idx),
        .level     (match_level)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_level_reg, m_found_reg};

    // read data only comes back while a scan is running
    a_read_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> state_reg == ilwf_pkg::ST_SCAN)
        else $error("ram read data outside of a scan");

    // the read counter never runs past the captured limit
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ilwf_pkg::ST_SCAN |-> rd_cnt_reg <= limit_reg)
        else $error("scan counter beyond limit");

    // a new result only appears out of the result state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ilwf_pkg::ST_RESULT)
        else $error("result loaded outside the result state");

    // the default level always points at entry 0
    a_default_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_level_reg == ilwf_pkg::LVL_DEFAULT |-> m_found_reg == '0)
        else $error("default level with nonzero index");

endmodule

// ===== hw/rtl/ilwf_ram.sv =====
// ilwf_ram: generic single write port, single read port ram with registered read
// no dependencies
module ilwf_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ilwf_match.sv =====
// ilwf_match: compares one table entry a cycle while cmp_en is set against the three
// search keys and keeps the first hit of each level; depends on ilwf_pkg
module ilwf_match #(
    parameter int IDX_W = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ilwf_pkg::scan_ctrl_t      ctrl,
    input  logic [ilwf_pkg::ID_W-1:0] key,
    input  logic [ilwf_pkg::ID_W-1:0] entry,
    input  logic [IDX_W-1:0]          entry_idx,
    output logic [IDX_W-1:0]          found_idx,
    output ilwf_pkg::match_level_t    level
);

    localparam int ID_W = ilwf_pkg::ID_W;
    localparam int FW   = ilwf_pkg::FIELD_W;

    logic [ID_W-1:0]  key_bank0;
    logic [ID_W-1:0]  key_all0;
    logic             hit_exact_reg, hit_bank0_reg, hit_all0_reg;
    logic             hit_exact_next, hit_bank0_next, hit_all0_next;
    logic [IDX_W-1:0] idx_exact_reg, idx_bank0_reg, idx_all0_reg;
    logic [IDX_W-1:0] idx_exact_next, idx_bank0_next, idx_all0_next;

    assign key_bank0 = {key[ID_W-1], {(2 * FW){1'b0}}, key[FW-1:0]};
    assign key_all0  = {key[ID_W-1], {(ID_W - 1){1'b0}}};

    always_comb begin
        hit_exact_next = hit_exact_reg;
        hit_bank0_next = hit_bank0_reg;
        hit_all0_next  = hit_all0_reg;
        idx_exact_next = idx_exact_reg;
        idx_bank0_next = idx_bank0_reg;
        idx_all0_next  = idx_all0_reg;
        if (ctrl.clear) begin
            hit_exact_next = 1'b0;
            hit_bank0_next = 1'b0;
            hit_all0_next  = 1'b0;
        end else if (ctrl.cmp_en) begin
            if (!hit_exact_reg && entry == key) begin
                hit_exact_next = 1'b1;
                idx_exact_next = entry_idx;
            end
            if (!hit_bank0_reg && entry == key_bank0) begin
                hit_bank0_next = 1'b1;
                idx_bank0_next = entry_idx;
            end
            if (!hit_all0_reg && entry == key_all0) begin
                hit_all0_next = 1'b1;
                idx_all0_next = entry_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_exact_reg <= 1'b0;
            hit_bank0_reg <= 1'b0;
            hit_all0_reg  <= 1'b0;
        end else begin
            hit_exact_reg <= hit_exact_next;
            hit_bank0_reg <= hit_bank0_next;
            hit_all0_reg  <= hit_all0_next;
        end
        idx_exact_reg <= idx_exact_next;
        idx_bank0_reg <= idx_bank0_next;
        idx_all0_reg  <= idx_all0_next;
    end

    // priority: exact, then bank zero, then all zero, else entry 0
    always_comb begin
        if (hit_exact_reg) begin
            found_idx = idx_exact_reg;
            level     = ilwf_pkg::LVL_EXACT;
        end else if (hit_bank0_reg) begin
            found_idx = idx_bank0_reg;
            level     = ilwf_pkg::LVL_BANK0;
        end else if (hit_all0_reg) begin
            found_idx = idx_all0_reg;
            level     = ilwf_pkg::LVL_ALL0;
        end else begin
            found_idx = '0;
            level     = ilwf_pkg::LVL_DEFAULT;
        end
    end

endmodule
